FILE: hw/rtl/tce_pkg.sv
// ---------------------------------------------------------------------------
// tce_pkg: shared types and constants of the tiny CPU execute unit
// Opcodes, the controller-to-datapath command word and the status word.
// ---------------------------------------------------------------------------
`default_nettype none

package tce_pkg;

   // Opcodes; codes above OP_POP are undefined and flagged
   typedef enum logic [3:0] {
      OP_LOAD  = 4'd0,
      OP_STORE = 4'd1,
      OP_ADD   = 4'd2,
      OP_SUB   = 4'd3,
      OP_MUL   = 4'd4,
      OP_DIV   = 4'd5,
      OP_MOD   = 4'd6,
      OP_PUSH  = 4'd7,
      OP_POP   = 4'd8
   } tce_op_type;

   // Bytes at and above this address come out of reset as all ones
   localparam int RESERVED_LOW = 512;
   localparam logic [7:0] FILL_HIGH = 8'hFF;
   localparam logic [7:0] FILL_LOW  = 8'h00;

   localparam int ITER_STEPS = 32;
   localparam int WORD_BYTES = 4;

   // Controller to datapath
   typedef struct packed {
      logic clear_step;
      logic load_req;
      logic rf_rd_a;
      logic rf_rd_b;
      logic cap_a;
      logic cap_b;
      logic set_addr;
      logic mem_rd;
      logic mem_cap;
      logic mem_wr;
      logic alu;
      logic iter_start;
      logic iter_step;
      logic iter_finish;
      logic writeback;
   } tce_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [3:0] op;
      logic       clear_last;
      logic       byte_last;
      logic       iter_last;
   } tce_sts_type;

endpackage

`default_nettype wire

FILE: hw/rtl/tce_ram.sv
// ---------------------------------------------------------------------------
// tce_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module tce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

FILE: hw/rtl/tce_datapath.sv
// ---------------------------------------------------------------------------
// tce_datapath: registers, memories and arithmetic of the execute unit
// Register file, byte memory, stack pointer, flags, shared mul/div unit
// and the response word register.
// ---------------------------------------------------------------------------
`default_nettype none

module tce_datapath #(
   parameter int MEM_BYTES  = 2048,
   parameter int STACK_BASE = 1024
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tce_pkg::tce_cmd_type cmd,
   output tce_pkg::tce_sts_type     sts,
   input  wire logic [3:0]          req_type,
   input  wire logic [3:0]          req_target_reg,
   input  wire logic [7:0]          req_first_operand,
   input  wire logic [7:0]          req_second_operand,
   input  wire logic                csr_we,
   input  wire logic                csr_big_endian,
   output logic signed [31:0]       rsp_result_value,
   output logic                     rsp_reg_written,
   output logic                     rsp_overflow_out,
   output logic                     rsp_divide_by_zero,
   output logic                     rsp_bad_opcode,
   output logic [10:0]              rsp_stack_top
);

   import tce_pkg::*;

   localparam int ADDR_W   = $clog2(MEM_BYTES);
   localparam int SP_RESET = STACK_BASE % MEM_BYTES;
   localparam logic [ADDR_W:0] MEM_SIZE = (ADDR_W+1)'(MEM_BYTES);

   // latched request
   logic [3:0] op_ff, rt_ff;
   logic [7:0] f1_ff, f2_ff;

   // architectural state
   logic              big_endian_ff;
   logic [ADDR_W-1:0] sp_ff;
   logic              flag_ff;
   logic [15:0]       rf_valid_ff;

   // working registers
   logic [31:0]       a_ff, b_ff, res_ff, word_ff;
   logic [ADDR_W-1:0] byte_addr_ff;
   logic [1:0]        byte_idx_ff;
   logic [ADDR_W-1:0] clr_ff;
   logic              rf_rd_vld_ff;
   logic              dz_ff;
   logic [63:0]       acc_ff;
   logic [31:0]       mb_ff;
   logic              neg_ff;
   logic [4:0]        cnt_ff;

   // ---- op class decode
   logic is_src_rt, is_arith_wr, is_known;
   always_comb begin
      is_src_rt   = (op_ff == OP_STORE) || (op_ff == OP_PUSH);
      is_arith_wr = (op_ff == OP_ADD) || (op_ff == OP_SUB) || (op_ff == OP_MUL) ||
                    (op_ff == OP_DIV) || (op_ff == OP_MOD);
      is_known    = (op_ff <= OP_POP);
   end

   // ---- register file
   logic [3:0]  rf_raddr;
   logic [31:0] rf_rdata, rf_word;
   logic [31:0] wb_value;
   logic        wb_reg;

   assign rf_raddr = cmd.rf_rd_a ? (is_src_rt ? rt_ff : f1_ff[3:0]) : f2_ff[3:0];
   assign rf_word  = rf_rd_vld_ff ? rf_rdata : 32'd0;

   tce_ram #(.WIDTH(32), .DEPTH(16)) u_rf (
      .clock (clock),
      .we    (cmd.writeback && wb_reg),
      .waddr (rt_ff),
      .wdata (wb_value),
      .raddr (rf_raddr),
      .rdata (rf_rdata)
   );

   // ---- data memory
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata, mem_rdata, init_byte;
   logic [1:0]        byte_pos;

   assign byte_pos  = big_endian_ff ? (2'd3 - byte_idx_ff) : byte_idx_ff;
   assign init_byte = (24'(clr_ff) >= 24'(RESERVED_LOW)) ? FILL_HIGH : FILL_LOW;
   assign mem_we    = cmd.clear_step || cmd.mem_wr;
   assign mem_waddr = cmd.clear_step ? clr_ff : byte_addr_ff;
   assign mem_wdata = cmd.clear_step ? init_byte : a_ff[{byte_pos, 3'b000} +: 8];

   tce_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (byte_addr_ff),
      .rdata (mem_rdata)
   );

   // ---- address arithmetic
   logic [23:0]       raw_mod;
   logic [ADDR_W:0]   sp_inc, sp_dec, ba_inc;
   logic [ADDR_W-1:0] sp_inc_w, sp_dec_w, ba_inc_w;

   always_comb begin
      // reduce {high, low} modulo the memory size, quotient below 256
      raw_mod = 24'({f1_ff, f2_ff});
      for (int k = 7; k >= 0; k--) begin
         if (raw_mod >= (24'(MEM_BYTES) << k)) begin
            raw_mod = raw_mod - (24'(MEM_BYTES) << k);
         end
      end
      sp_inc   = {1'b0, sp_ff} + (ADDR_W+1)'(WORD_BYTES);
      sp_dec   = {1'b0, sp_ff} + MEM_SIZE - (ADDR_W+1)'(WORD_BYTES);
      ba_inc   = {1'b0, byte_addr_ff} + (ADDR_W+1)'(1);
      sp_inc_w = (sp_inc >= MEM_SIZE) ? ADDR_W'(sp_inc - MEM_SIZE) : sp_inc[ADDR_W-1:0];
      sp_dec_w = (sp_dec >= MEM_SIZE) ? ADDR_W'(sp_dec - MEM_SIZE) : sp_dec[ADDR_W-1:0];
      ba_inc_w = (ba_inc >= MEM_SIZE) ? ADDR_W'(ba_inc - MEM_SIZE) : ba_inc[ADDR_W-1:0];
   end

   // ---- add / sub
   logic [31:0] sum, dif;
   assign sum = a_ff + b_ff;
   assign dif = a_ff - b_ff;

   // ---- shared multiply / divide step
   logic [31:0] ma, mb;
   logic [32:0] mul_hi;
   logic [63:0] div_sh;
   logic [32:0] div_diff;
   logic [63:0] acc_step;
   logic        mul_ovf;

   always_comb begin
      ma       = a_ff[31] ? (32'd0 - a_ff) : a_ff;
      mb       = b_ff[31] ? (32'd0 - b_ff) : b_ff;
      mul_hi   = {1'b0, acc_ff[63:32]} + (acc_ff[0] ? {1'b0, mb_ff} : 33'd0);
      div_sh   = {acc_ff[62:0], 1'b0};
      div_diff = {1'b0, div_sh[63:32]} - {1'b0, mb_ff};
      if (op_ff == OP_MUL) begin
         acc_step = {mul_hi, acc_ff[31:1]};
      end else if (!div_diff[32]) begin
         acc_step = {div_diff[31:0], div_sh[31:1], 1'b1};
      end else begin
         acc_step = div_sh;
      end
      // signed product fits 32 bits: magnitude up to 2^31 when negative
      mul_ovf = neg_ff ? ((acc_ff[63:32] != 32'd0) || (acc_ff[31] && (acc_ff[30:0] != 31'd0)))
                       : (acc_ff[63:31] != 33'd0);
   end

   // ---- writeback selection
   always_comb begin
      wb_reg = is_arith_wr || (op_ff == OP_LOAD) || (op_ff == OP_POP);
      if ((op_ff == OP_LOAD) || (op_ff == OP_POP)) begin
         wb_value = word_ff;
      end else if (is_src_rt) begin
         wb_value = a_ff;
      end else if (is_arith_wr) begin
         wb_value = res_ff;
      end else begin
         wb_value = 32'd0;
      end
   end

   // ---- status
   always_comb begin
      sts.op         = op_ff;
      sts.clear_last = (clr_ff == ADDR_W'(MEM_BYTES - 1));
      sts.byte_last  = (byte_idx_ff == 2'd3);
      sts.iter_last  = (cnt_ff == 5'(ITER_STEPS - 1));
   end

   // ---- control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b0;
         sp_ff         <= ADDR_W'(SP_RESET);
         flag_ff       <= 1'b0;
         rf_valid_ff   <= '0;
         clr_ff        <= '0;
      end else begin
         if (csr_we) begin
            big_endian_ff <= csr_big_endian;
         end
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         if (cmd.set_addr && (op_ff == OP_PUSH)) begin
            sp_ff <= sp_inc_w;
         end else if (cmd.set_addr && (op_ff == OP_POP)) begin
            sp_ff <= sp_dec_w;
         end
         if (cmd.alu) begin
            flag_ff <= (op_ff == OP_ADD) ? ((a_ff[31] == b_ff[31]) && (sum[31] != a_ff[31]))
                                         : ((a_ff[31] != b_ff[31]) && (dif[31] != a_ff[31]));
         end else if (cmd.iter_finish && (op_ff == OP_MUL)) begin
            flag_ff <= mul_ovf;
         end
         if (cmd.writeback && wb_reg) begin
            rf_valid_ff[rt_ff] <= 1'b1;
         end
      end
   end

   // ---- working and payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff <= req_type;
         rt_ff <= req_target_reg;
         f1_ff <= req_first_operand;
         f2_ff <= req_second_operand;
         dz_ff <= 1'b0;
      end
      if (cmd.rf_rd_a || cmd.rf_rd_b) begin
         rf_rd_vld_ff <= rf_valid_ff[rf_raddr];
      end
      if (cmd.cap_a) begin
         a_ff <= rf_word;
      end
      if (cmd.cap_b) begin
         b_ff <= rf_word;
      end
      if (cmd.set_addr) begin
         byte_idx_ff <= 2'd0;
         if (op_ff == OP_PUSH) begin
            byte_addr_ff <= sp_ff;
         end else if (op_ff == OP_POP) begin
            byte_addr_ff <= sp_dec_w;
         end else begin
            byte_addr_ff <= raw_mod[ADDR_W-1:0];
         end
      end
      if (cmd.mem_cap || cmd.mem_wr) begin
         byte_idx_ff  <= byte_idx_ff + 2'd1;
         byte_addr_ff <= ba_inc_w;
      end
      if (cmd.mem_cap) begin
         word_ff[{byte_pos, 3'b000} +: 8] <= mem_rdata;
      end
      if (cmd.alu) begin
         res_ff <= (op_ff == OP_ADD) ? sum : dif;
      end
      if (cmd.iter_start) begin
         acc_ff <= {32'd0, ma};
         mb_ff  <= mb;
         neg_ff <= a_ff[31] ^ b_ff[31];
         cnt_ff <= 5'd0;
         dz_ff  <= (op_ff != OP_MUL) && (mb == 32'd0);
      end
      if (cmd.iter_step) begin
         acc_ff <= acc_step;
         cnt_ff <= cnt_ff + 5'd1;
      end
      if (cmd.iter_finish) begin
         if (op_ff == OP_MUL) begin
            res_ff <= neg_ff ? (32'd0 - acc_ff[31:0]) : acc_ff[31:0];
         end else if (dz_ff) begin
            // zero divisor: quotient 0, remainder is the dividend magnitude
            res_ff <= (op_ff == OP_DIV) ? 32'd0 : ma;
         end else if (op_ff == OP_DIV) begin
            res_ff <= neg_ff ? (32'd0 - acc_ff[31:0]) : acc_ff[31:0];
         end else begin
            res_ff <= acc_ff[63:32];
         end
      end
      if (cmd.writeback) begin
         rsp_result_value   <= wb_value;
         rsp_reg_written    <= wb_reg;
         rsp_overflow_out   <= flag_ff;
         rsp_divide_by_zero <= dz_ff;
         rsp_bad_opcode     <= !is_known;
         rsp_stack_top      <= 11'(16'(sp_ff));
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/tce_ctrl.sv
// ---------------------------------------------------------------------------
// tce_ctrl: sequencer of the execute unit
// Steps each instruction through register reads, memory or arithmetic
// phases and hands the word to the response register.
// ---------------------------------------------------------------------------
`default_nettype none

module tce_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire tce_pkg::tce_sts_type sts,
   output tce_pkg::tce_cmd_type      cmd
);

   import tce_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_RA, ST_RB, ST_CB, ST_MRD, ST_MCAP, ST_MWR,
      ST_ALU, ST_ITS, ST_ITR, ST_ITF, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // command decode and next state
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid && !rsp_ready;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_RA;
            end
         end
         ST_RA: begin
            cmd.rf_rd_a = 1'b1;
            state_in    = ST_RB;
         end
         ST_RB: begin
            cmd.rf_rd_b = 1'b1;
            cmd.cap_a   = 1'b1;
            state_in    = ST_CB;
         end
         ST_CB: begin
            cmd.cap_b    = 1'b1;
            cmd.set_addr = 1'b1;
            priority if ((sts.op == OP_LOAD) || (sts.op == OP_POP)) begin
               state_in = ST_MRD;
            end else if ((sts.op == OP_STORE) || (sts.op == OP_PUSH)) begin
               state_in = ST_MWR;
            end else if ((sts.op == OP_ADD) || (sts.op == OP_SUB)) begin
               state_in = ST_ALU;
            end else if ((sts.op == OP_MUL) || (sts.op == OP_DIV) ||
                         (sts.op == OP_MOD)) begin
               state_in = ST_ITS;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MRD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_MCAP;
         end
         ST_MCAP: begin
            cmd.mem_cap = 1'b1;
            state_in    = sts.byte_last ? ST_DONE : ST_MRD;
         end
         ST_MWR: begin
            cmd.mem_wr = 1'b1;
            if (sts.byte_last) state_in = ST_DONE;
         end
         ST_ALU: begin
            cmd.alu  = 1'b1;
            state_in = ST_DONE;
         end
         ST_ITS: begin
            cmd.iter_start = 1'b1;
            state_in       = ST_ITR;
         end
         ST_ITR: begin
            cmd.iter_step = 1'b1;
            if (sts.iter_last) state_in = ST_ITF;
         end
         ST_ITF: begin
            cmd.iter_finish = 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.writeback = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rsp_valid <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/tiny_cpu_execute_unit.sv
// From accepted request to response valid, add/sub take the shortest path, then
// store/push, then load/pop; the 32-step shared mul/div unit sets the worst case.
// One instruction is in flight at a time; the next can be taken as soon as the
// response is registered, while that response may still be waiting.
// After reset the byte memory is initialised in a sweep over all MEM_BYTES bytes,
// during which no request is taken; the configuration port is always ready.
// ---------------------------------------------------------------------------
// tiny_cpu_execute_unit: execute stage of a small register machine
// Runs load, store, add, sub, mul, div, mod, push and pop on sixteen
// 32-bit registers and a byte memory with selectable word byte order.
// ---------------------------------------------------------------------------
`default_nettype none

module tiny_cpu_execute_unit #(
   parameter int MEM_BYTES  = 2048,
   parameter int STACK_BASE = 1024
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [3:0]    req_type,
   input  wire logic [3:0]    req_target_reg,
   input  wire logic [7:0]    req_first_operand,
   input  wire logic [7:0]    req_second_operand,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic signed [31:0] rsp_result_value,
   output logic               rsp_reg_written,
   output logic               rsp_overflow_out,
   output logic               rsp_divide_by_zero,
   output logic               rsp_bad_opcode,
   output logic [10:0]        rsp_stack_top,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic          csr_big_endian
);

   import tce_pkg::*;

   tce_cmd_type cmd;
   tce_sts_type sts;

   assign csr_ready = 1'b1;

   // sequencer
   tce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // registers, memories and arithmetic
   tce_datapath #(.MEM_BYTES(MEM_BYTES), .STACK_BASE(STACK_BASE)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_type           (req_type),
      .req_target_reg     (req_target_reg),
      .req_first_operand  (req_first_operand),
      .req_second_operand (req_second_operand),
      .csr_we             (csr_valid && csr_ready),
      .csr_big_endian     (csr_big_endian),
      .rsp_result_value   (rsp_result_value),
      .rsp_reg_written    (rsp_reg_written),
      .rsp_overflow_out   (rsp_overflow_out),
      .rsp_divide_by_zero (rsp_divide_by_zero),
      .rsp_bad_opcode     (rsp_bad_opcode),
      .rsp_stack_top      (rsp_stack_top)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/tce_checker.sv
// ---------------------------------------------------------------------------
// tce_checker: port-level checks of the execute unit
// Watches the request and response channels and binds to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module tce_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_result_value,
   input wire logic        rsp_reg_written,
   input wire logic        rsp_divide_by_zero,
   input wire logic        rsp_bad_opcode
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value))
      else $error("response changed while stalled");

   // one instruction in flight: no back-to-back accept
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // undefined opcode gives zero result, no write and no divide by zero
   a_bad_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_opcode |->
         rsp_result_value == 32'd0 && !rsp_reg_written && !rsp_divide_by_zero)
      else $error("undefined opcode had an effect");

   // nothing leaves and nothing is taken straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("activity after reset");

endmodule

bind tiny_cpu_execute_unit tce_checker u_tce_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_result_value   (rsp_result_value),
   .rsp_reg_written    (rsp_reg_written),
   .rsp_divide_by_zero (rsp_divide_by_zero),
   .rsp_bad_opcode     (rsp_bad_opcode)
);

`default_nettype wire

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench of the tiny CPU execute unit
// Drives decoded instructions through the request channel, predicts each
// response with a behavioural model of registers, memory, stack and flags,
// and compares every response word field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import tce_pkg::*;

   localparam int MEM_SIZE   = 2048;
   localparam int STACK_INIT = 1024;

   typedef struct packed {
      logic [31:0] value;
      logic        wr;
      logic        ovf;
      logic        dz;
      logic        bad;
      logic [10:0] sp;
   } exec_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [3:0] req_type = '0;
   logic [3:0] req_target_reg = '0;
   logic [7:0] req_first_operand = '0;
   logic [7:0] req_second_operand = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_result_value;
   logic rsp_reg_written, rsp_overflow_out, rsp_divide_by_zero, rsp_bad_opcode;
   logic [10:0] rsp_stack_top;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_big_endian = 1'b0;

   // Model state
   logic [31:0] regs_m [16];
   logic [7:0]  mem_m [MEM_SIZE];
   logic [10:0] sp_m;
   logic        ovf_m;
   logic        big_end_m;

   exec_result_type expected_q[$];
   int   failures = 0;
   int   words_checked = 0;
   int   sent = 0;
   int   send_idle = 0;   // per cent
   int   recv_idle = 0;

   always #1 clock = ~clock;

   tiny_cpu_execute_unit dut (
      .clock, .reset, .req_valid, .req_ready, .req_type, .req_target_reg,
      .req_first_operand, .req_second_operand, .rsp_valid, .rsp_ready,
      .rsp_result_value, .rsp_reg_written, .rsp_overflow_out,
      .rsp_divide_by_zero, .rsp_bad_opcode, .rsp_stack_top,
      .csr_valid, .csr_ready, .csr_big_endian
   );

   // Memory word access in the selected byte order, with address wrap
   function automatic logic [31:0] mem_read_word(input int addr);
      logic [31:0] v;
      v = '0;
      for (int i = 0; i < 4; i++) begin
         if (big_end_m) v[8*(3-i) +: 8] = mem_m[(addr + i) % MEM_SIZE];
         else           v[8*i +: 8]     = mem_m[(addr + i) % MEM_SIZE];
      end
      return v;
   endfunction

   task automatic mem_write_word(input int addr, input logic [31:0] v);
      for (int i = 0; i < 4; i++) begin
         if (big_end_m) mem_m[(addr + i) % MEM_SIZE] = v[8*(3-i) +: 8];
         else           mem_m[(addr + i) % MEM_SIZE] = v[8*i +: 8];
      end
   endtask

   function automatic logic [31:0] abs32(input logic [31:0] v);
      return v[31] ? -v : v;
   endfunction

   // Predict one instruction and update the model state
   task automatic execute_model(input logic [3:0] op, input logic [3:0] rt,
                                input logic [7:0] f1, input logic [7:0] f2,
                                output exec_result_type r);
      logic [31:0] a, b, ma, mb, q;
      logic signed [63:0] wide;
      int addr;
      a = regs_m[f1[3:0]];
      b = regs_m[f2[3:0]];
      addr = {f1, f2} % MEM_SIZE;
      r = '0;
      case (op)
         OP_LOAD: begin
            r.value = mem_read_word(addr);
            regs_m[rt] = r.value; r.wr = 1'b1;
         end
         OP_STORE: begin
            r.value = regs_m[rt];
            mem_write_word(addr, r.value);
         end
         OP_ADD, OP_SUB, OP_MUL: begin
            if (op == OP_ADD)
               wide = 64'(signed'(a)) + 64'(signed'(b));
            else if (op == OP_SUB)
               wide = 64'(signed'(a)) - 64'(signed'(b));
            else
               wide = 64'(signed'(a)) * 64'(signed'(b));
            r.value = wide[31:0];
            ovf_m = (wide != 64'(signed'(wide[31:0])));
            regs_m[rt] = r.value; r.wr = 1'b1;
         end
         OP_DIV, OP_MOD: begin
            ma = abs32(a);
            mb = abs32(b);
            if (mb == 0) begin
               r.dz = 1'b1;
               r.value = (op == OP_DIV) ? 32'd0 : ma;
            end else if (op == OP_DIV) begin
               q = ma / mb;
               r.value = (a[31] ^ b[31]) ? -q : q;
            end else begin
               r.value = ma % mb;
            end
            regs_m[rt] = r.value; r.wr = 1'b1;
         end
         OP_PUSH: begin
            r.value = regs_m[rt];
            mem_write_word(sp_m, r.value);
            sp_m = sp_m + 11'd4;
         end
         OP_POP: begin
            sp_m = sp_m - 11'd4;
            r.value = mem_read_word(sp_m);
            regs_m[rt] = r.value; r.wr = 1'b1;
         end
         default: r.bad = 1'b1;
      endcase
      r.ovf = ovf_m;
      r.sp = sp_m;
   endtask

   // Send one instruction word; predict it at acceptance.
   // Valid stays up after acceptance until the next word or a drain.
   task automatic send_instr(input logic [3:0] op, input logic [3:0] rt,
                             input logic [7:0] f1, input logic [7:0] f2);
      exec_result_type r;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_target_reg <= rt;
      req_first_operand <= f1;
      req_second_operand <= f2;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      execute_model(op, rt, f1, f2, r);
      expected_q.push_back(r);
      sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_endian(input logic be);
      wait_drained();
      csr_valid <= 1'b1;
      csr_big_endian <= be;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      big_end_m = be;
      csr_valid <= 1'b0;
   endtask

   // Random receiver stall
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // Response checker
   always @(posedge clock) begin
      exec_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $error("response word with nothing expected");
            failures++;
         end else begin
            e = expected_q.pop_front();
            words_checked++;
            if (rsp_result_value !== e.value) begin
               $error("result_value exp %h got %h", e.value, rsp_result_value);
               failures++;
            end
            if (rsp_reg_written !== e.wr) begin
               $error("reg_written exp %b got %b", e.wr, rsp_reg_written);
               failures++;
            end
            if (rsp_overflow_out !== e.ovf) begin
               $error("overflow_out exp %b got %b", e.ovf, rsp_overflow_out);
               failures++;
            end
            if (rsp_divide_by_zero !== e.dz) begin
               $error("divide_by_zero exp %b got %b", e.dz, rsp_divide_by_zero);
               failures++;
            end
            if (rsp_bad_opcode !== e.bad) begin
               $error("bad_opcode exp %b got %b", e.bad, rsp_bad_opcode);
               failures++;
            end
            if (rsp_stack_top !== e.sp) begin
               $error("stack_top exp %h got %h", e.sp, rsp_stack_top);
               failures++;
            end
         end
      end
   end

   // Directed: extremes, every opcode, zero divisor, wrap
   task automatic test_directed();
      // r1 = 0xFFFFFFFF (high memory), r2 = 0 (low memory)
      send_instr(OP_LOAD, 4'd1, 8'h02, 8'h00);
      send_instr(OP_LOAD, 4'd2, 8'h00, 8'h10);
      send_instr(OP_SUB, 4'd3, 8'h02, 8'h01);      // r3 = 1
      send_instr(OP_ADD, 4'd4, 8'h03, 8'h03);      // 2
      // build 256 by repeated squaring of 2: 2, 4, 16, 256
      send_instr(OP_MUL, 4'd4, 8'h04, 8'h04);
      send_instr(OP_MUL, 4'd4, 8'h04, 8'h04);
      send_instr(OP_MUL, 4'd4, 8'h04, 8'h04);
      send_instr(OP_MUL, 4'd5, 8'h04, 8'h04);      // 2^16
      send_instr(OP_MUL, 4'd5, 8'hF4, 8'h34);      // 2^8*2^8 - high bits ignored
      send_instr(OP_ADD, 4'd6, 8'h04, 8'h04);      // 2^9
      send_instr(OP_MUL, 4'd6, 8'h06, 8'h04);      // 2^17
      send_instr(OP_SUB, 4'd7, 8'h02, 8'h03);      // -1
      send_instr(OP_DIV, 4'd8, 8'h03, 8'h02);      // zero divisor
      send_instr(OP_MOD, 4'd8, 8'h07, 8'h02);      // zero divisor, mod
      send_instr(OP_DIV, 4'd9, 8'h07, 8'h07);
      send_instr(OP_MOD, 4'd9, 8'h04, 8'h07);
      send_instr(OP_STORE, 4'd7, 8'hFF, 8'hFE);    // wraps past end of memory
      send_instr(OP_LOAD, 4'd10, 8'h07, 8'hFE);
      send_instr(OP_PUSH, 4'd4, 8'h00, 8'h00);
      send_instr(OP_POP, 4'd11, 8'h00, 8'h00);
      send_instr(OP_POP, 4'd12, 8'h00, 8'h00);
      send_instr(4'd9, 4'd0, 8'hFF, 8'hFF);
      send_instr(4'd15, 4'd15, 8'hAA, 8'h55);
      send_instr(OP_ADD, 4'd15, 8'hFF, 8'h00);
   endtask

   // Random instruction mix; mostly defined opcodes, some drawn from all sixteen codes
   task automatic test_random(input int n);
      logic [3:0] op;
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 88) op = 4'($urandom_range(0, 8));
         else op = 4'($urandom_range(0, 15));
         if (op == OP_LOAD || op == OP_STORE)
            send_instr(op, 4'($urandom), 8'($urandom), 8'($urandom));
         else
            send_instr(op, 4'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   // Push/pop sequences around the stack wrap
   task automatic test_stack(input int n);
      for (int i = 0; i < n; i++)
         send_instr(OP_PUSH, 4'($urandom), 8'($urandom), 8'($urandom));
      for (int i = 0; i < n + 2; i++)
         send_instr(OP_POP, 4'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic test_byte_order(input logic be);
      write_endian(be);
      send_instr(OP_ADD, 4'd1, 8'h05, 8'h06);
      send_instr(OP_STORE, 4'd1, 8'h01, 8'h00);
      send_instr(OP_LOAD, 4'd2, 8'h01, 8'h00);
      send_instr(OP_LOAD, 4'd3, 8'h01, 8'h01);
      test_random(40);
   endtask

   // Model reset state
   initial begin
      for (int i = 0; i < 16; i++) regs_m[i] = '0;
      for (int i = 0; i < MEM_SIZE; i++) mem_m[i] = (i >= RESERVED_LOW) ? FILL_HIGH : FILL_LOW;
      sp_m = 11'(STACK_INIT % MEM_SIZE);
      ovf_m = 1'b0;
      big_end_m = 1'b0;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      send_idle = 30; recv_idle = 51;
      test_directed();
      test_random(50);
      // hold off until the block has drained
      wait_drained();
      test_stack(12);
      send_idle = 51; recv_idle = 30;
      test_byte_order(1'b1);
      test_random(30);
      send_idle = 0; recv_idle = 0;
      test_byte_order(1'b0);
      test_stack(270);
      test_random(20);
      wait_drained();
      $display("Ran %0d instructions, %0d response words checked, both byte orders,",
               sent, words_checked);
      $display("stack wrap, overflow, zero divisor and undefined opcodes included.");
      if (failures == 0 && expected_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
